// ----- rtl/core/tbns_pkg.sv -----
package tbns_pkg;

  localparam int NODES_DEF = 64;
  localparam int EDGES_DEF = 512;
  localparam int WEIGHT_BITS_DEF = 8;
  localparam int MAX_RUN = 64;

  typedef enum logic [1:0] {
    REQ_EDGE  = 2'd0,
    REQ_RANGE = 2'd1,
    REQ_STATE = 2'd2,
    REQ_RUN   = 2'd3
  } req_type_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [8:0]  edge_index;
    logic [5:0]  source_node;
    logic signed [7:0] weight;
    logic [5:0]  node_index;
    logic [9:0]  range_begin;
    logic [9:0]  range_end;
    logic [63:0] state_in;
    logic [6:0]  steps;
  } in_item_t;

  typedef struct packed {
    logic [63:0] state_vector;
    logic [6:0]  step_index;
    logic        last;
  } out_item_t;

endpackage

// ----- rtl/core/tbns_ram.sv -----
module tbns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tbns_front.sv -----
module tbns_front import tbns_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t item,
  input  logic     push,
  output logic     full,
  output in_item_t q_item,
  output logic     q_valid,
  input  logic     q_take
);

  // Two-entry queue that decouples request intake from step execution.
  in_item_t   slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= item;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- rtl/core/tbns_back.sv -----
module tbns_back import tbns_pkg::*; #(
  parameter int NODES = NODES_DEF,
  parameter int EDGES = EDGES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] node_count,
  input  in_item_t   q_item,
  input  logic       q_valid,
  output logic       q_take,
  output out_item_t  res,
  output logic       res_valid,
  input  logic       res_take
);

  localparam int EA = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int NA = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SW = WEIGHT_BITS + EA + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_NODE, S_RANGE, S_EDGE, S_DONE, S_OUT
  } state_t;

  state_t      state;
  logic [63:0] cur;
  logic [63:0] nxt;
  logic [NA-1:0] node;
  logic [NA:0]   n_use;
  logic [6:0]  steps_tot;
  logic [6:0]  step_no;
  logic [10:0] e_ptr;
  logic [10:0] e_end;
  logic        e_pend;
  logic signed [SW-1:0] sum;
  logic [63:0] mask;

  logic          ew_we;
  logic [EA-1:0] e_raddr;
  logic [5:0]    src_rd;
  logic [WEIGHT_BITS-1:0] w_rd;
  logic          rw_we;
  logic [9:0]    rb_rd;
  logic [9:0]    re_rd;
  logic [10:0]   re_clip;
  logic [6:0]    nc_clip;

  assign ew_we = (state == S_IDLE) && q_valid && (q_item.req_type == REQ_EDGE)
                 && (32'(q_item.edge_index) < EDGES);
  assign rw_we = (state == S_IDLE) && q_valid && (q_item.req_type == REQ_RANGE)
                 && ({1'b0, q_item.node_index} < 7'(NODES));
  assign e_raddr = EA'(e_ptr);

  tbns_ram #(.WIDTH(6), .DEPTH(EDGES)) u_src (
    .clk(clk), .we(ew_we), .waddr(EA'(q_item.edge_index)),
    .wdata(q_item.source_node), .raddr(e_raddr), .rdata(src_rd));
  tbns_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(EDGES)) u_wgt (
    .clk(clk), .we(ew_we), .waddr(EA'(q_item.edge_index)),
    .wdata(WEIGHT_BITS'(q_item.weight)), .raddr(e_raddr), .rdata(w_rd));
  tbns_ram #(.WIDTH(10), .DEPTH(NODES)) u_rb (
    .clk(clk), .we(rw_we), .waddr(q_item.node_index[NA-1:0]),
    .wdata(q_item.range_begin), .raddr(node), .rdata(rb_rd));
  tbns_ram #(.WIDTH(10), .DEPTH(NODES)) u_re (
    .clk(clk), .we(rw_we), .waddr(q_item.node_index[NA-1:0]),
    .wdata(q_item.range_end), .raddr(node), .rdata(re_rd));

  always_comb begin
    nc_clip = node_count;
    if (nc_clip == 7'd0) begin
      nc_clip = 7'd1;
    end else if (nc_clip > 7'(NODES)) begin
      nc_clip = 7'(NODES);
    end
    re_clip = (32'(re_rd) > EDGES) ? 11'(EDGES) : {1'b0, re_rd};
  end

  function automatic logic [63:0] mask_of(input logic [6:0] n);
    logic [63:0] m;
    m = (n >= 7'd64) ? '1 : ((64'd1 << n) - 64'd1);
    return m;
  endfunction

  assign q_take = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_item.req_type)
              REQ_STATE: cur <= q_item.state_in & mask_of(nc_clip);
              REQ_RUN: begin
                // Bits of unused nodes are cleared even when no step runs.
                cur <= cur & mask_of(nc_clip);
                if (q_item.steps != 7'd0) begin
                  steps_tot <= (q_item.steps > 7'(MAX_RUN)) ? 7'(MAX_RUN)
                                                           : q_item.steps;
                  step_no <= 7'd1;
                  n_use   <= (NA+1)'(nc_clip);
                  mask    <= mask_of(nc_clip);
                  nxt     <= cur & mask_of(nc_clip);
                  node    <= '0;
                  state   <= S_NODE;
                end
              end
              default: ;
            endcase
          end
        end
        S_NODE: state <= S_RANGE;
        S_RANGE: begin
          e_ptr  <= {1'b0, rb_rd};
          e_end  <= re_clip;
          e_pend <= 1'b0;
          sum    <= '0;
          state  <= S_EDGE;
        end
        S_EDGE: begin
          // One edge read issued per cycle; data arrives the next cycle.
          if (e_pend && cur[src_rd]) begin
            sum <= sum + SW'(signed'(w_rd));
          end
          if (e_ptr < e_end) begin
            e_ptr  <= e_ptr + 11'd1;
            e_pend <= 1'b1;
          end else if (e_pend) begin
            e_pend <= 1'b0;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (sum > 0) begin
            nxt[node] <= 1'b1;
          end else if (sum < 0) begin
            nxt[node] <= 1'b0;
          end
          if ({1'b0, node} == n_use - (NA+1)'(1)) begin
            state <= S_OUT;
          end else begin
            node  <= node + NA'(1);
            state <= S_NODE;
          end
        end
        S_OUT: begin
          if (!res_valid) begin
            res.state_vector <= nxt & mask;
            res.step_index   <= step_no;
            res.last         <= (step_no == steps_tot);
            res_valid        <= 1'b1;
            cur              <= nxt & mask;
            nxt              <= nxt & mask;
            node             <= '0;
            if (step_no == steps_tot) begin
              state <= S_IDLE;
            end else begin
              step_no <= step_no + 7'd1;
              state   <= S_NODE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (res_valid && res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/threshold_boolean_network_stepper.sv -----
// A run starts from idle; each step then visits every node in use through the
// NODE, RANGE, EDGE and DONE states and ends in OUT, and the edge table is read
// one edge per cycle. Other requests are handled in the idle state.
// Throughput: one request at a time in the back end; a two-entry queue takes more.
// Reset: rst is synchronous, active high; it clears the state vector and result,
// sets node_count to NODES and empties the queue. Tables are undefined until written.
module threshold_boolean_network_stepper import tbns_pkg::*; #(
  parameter int NODES = NODES_DEF,
  parameter int EDGES = EDGES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata,
  input  in_item_t  in_item,
  input  logic      push,
  output logic      full,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);

  // Number of nodes in use; clipped to 1..NODES where it is used.
  logic [6:0] node_count;
  in_item_t   q_item;
  logic       q_valid;
  logic       q_take;
  logic       res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 7'(NODES);
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  // The front end queues requests so that intake waits on a run only once two
  // requests are queued behind it.
  tbns_front u_front (
    .clk(clk), .rst(rst), .item(in_item), .push(push), .full(full),
    .q_item(q_item), .q_valid(q_valid), .q_take(q_take));

  // The back end applies table writes and walks the edge lists step by step.
  // Its result register lets the next step proceed while a result waits.
  tbns_back #(.NODES(NODES), .EDGES(EDGES), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk(clk), .rst(rst), .node_count(node_count), .q_item(q_item),
    .q_valid(q_valid), .q_take(q_take), .res(out_item), .res_valid(res_valid),
    .res_take(pop));

  assign empty = !res_valid;

endmodule

// ----- tb/threshold_boolean_network_stepper_test.sv -----
`timescale 1ns / 1ps

module threshold_boolean_network_stepper_test;
  import tbns_pkg::*;

  // Clock, reset and the block's ports.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  in_item_t in_item = '0;
  logic push = 1'b0;
  logic full;
  out_item_t out_item;
  logic empty;
  logic pop = 1'b0;

  // A step can walk every edge of every node, so the watchdog only fires after a
  // long quiet stretch.
  localparam int QUIET_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 50;
  localparam int IN_BITS = $bits(in_item_t);
  // Edges written at the low and the high end of the table.
  localparam int LOW_EDGES = 8;
  localparam int HIGH_EDGES = 4;

  always #5 clk = ~clk;

  threshold_boolean_network_stepper DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_item(in_item),
    .push(push),
    .full(full),
    .out_item(out_item),
    .empty(empty),
    .pop(pop)
  );

  // Shadow copy of the network: tables, node count and the state vector.
  logic [5:0] shadow_source [EDGES_DEF];
  logic signed [7:0] shadow_weight [EDGES_DEF];
  logic [9:0] shadow_begin [NODES_DEF];
  logic [9:0] shadow_end [NODES_DEF];
  logic [63:0] shadow_state = '0;
  logic [6:0] shadow_node_count = 7'd64;

  out_item_t expected_states[$];
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic int active_nodes();
    if (shadow_node_count < 7'd1) return 1;
    if (shadow_node_count > NODES_DEF) return NODES_DEF;
    return shadow_node_count;
  endfunction

  function automatic logic [63:0] active_mask(int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // One synchronous update: each node in use sums the weights of edges whose
  // source was 1 in the old state: set on a positive sum, cleared on a negative one.
  function automatic logic [63:0] next_state(logic [63:0] old, int n_use);
    logic [63:0] nxt;
    int sum;
    int stop;
    nxt = old;
    for (int n = 0; n < n_use; n++) begin
      sum = 0;
      stop = (shadow_end[n] > EDGES_DEF) ? EDGES_DEF : shadow_end[n];
      for (int e = shadow_begin[n]; e < stop; e++) begin
        if (old[shadow_source[e]]) sum += shadow_weight[e];
      end
      if (sum > 0) nxt[n] = 1'b1;
      else if (sum < 0) nxt[n] = 1'b0;
    end
    return nxt & active_mask(n_use);
  endfunction

  // Applies one accepted request to the shadow network and queues the
  // state vectors that a run request must produce.
  task automatic apply_request(in_item_t it);
    int n_use;
    int count;
    logic [63:0] st;
    out_item_t res;
    n_use = active_nodes();
    case (req_type_t'(it.req_type))
      REQ_EDGE: begin
        shadow_source[it.edge_index] = it.source_node;
        shadow_weight[it.edge_index] = it.weight;
      end
      REQ_RANGE: begin
        shadow_begin[it.node_index] = it.range_begin;
        shadow_end[it.node_index] = it.range_end;
      end
      REQ_STATE: begin
        shadow_state = it.state_in & active_mask(n_use);
      end
      REQ_RUN: begin
        count = (it.steps > MAX_RUN) ? MAX_RUN : it.steps;
        st = shadow_state & active_mask(n_use);
        for (int k = 1; k <= count; k++) begin
          st = next_state(st, n_use);
          res.state_vector = st;
          res.step_index = 7'(k);
          res.last = (k == count);
          expected_states.push_back(res);
        end
        shadow_state = st;
      end
    endcase
  endtask

  // Sends one request after a random gap; mostly short gaps, a few long ones,
  // and some back-to-back requests. Inputs change on the falling edge.
  task automatic send_request(in_item_t it);
    int gap;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: gap = 0;
      9: gap = $urandom_range(20, 60);
      default: gap = $urandom_range(1, 4);
    endcase
    repeat (gap) @(negedge clk);
    push = 1'b1;
    in_item = it;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_request(it);
    @(negedge clk);
    push = 1'b0;
  endtask

  function automatic in_item_t make_edge(int idx, int src, int w);
    in_item_t it;
    it = in_item_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom}));
    it.req_type = REQ_EDGE;
    it.edge_index = 9'(idx);
    it.source_node = 6'(src);
    it.weight = 8'(w);
    return it;
  endfunction

  function automatic in_item_t make_range(int node, int first, int stop);
    in_item_t it;
    it = in_item_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom}));
    it.req_type = REQ_RANGE;
    it.node_index = 6'(node);
    it.range_begin = 10'(first);
    it.range_end = 10'(stop);
    return it;
  endfunction

  function automatic in_item_t make_state(logic [63:0] value);
    in_item_t it;
    it = in_item_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom}));
    it.req_type = REQ_STATE;
    it.state_in = value;
    return it;
  endfunction

  function automatic in_item_t make_run(int count);
    in_item_t it;
    it = in_item_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom}));
    it.req_type = REQ_RUN;
    it.steps = 7'(count);
    return it;
  endfunction

  // A short range inside the low edges, which are written up front, so the
  // range reads only written entries.
  function automatic in_item_t random_range(int node);
    int first;
    first = $urandom_range(0, LOW_EDGES - 1);
    return make_range(node, first, first + $urandom_range(0, LOW_EDGES - first));
  endfunction

  // Waits until every expected result has been popped, then lets a write or
  // set-state request still in the queue drain before touching the register.
  task automatic wait_idle();
    while (expected_states.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(int value);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = 7'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_node_count = 7'(value);
  endtask

  // Fills the low and high ends of the edge table and every node range. Runs
  // read only these entries. Weight and source extremes included.
  task automatic load_network();
    for (int e = 0; e < LOW_EDGES; e++) begin
      case (e % 4)
        0: send_request(make_edge(e, 0, -128));
        1: send_request(make_edge(e, 63, 127));
        2: send_request(make_edge(e, $urandom_range(0, 63), 1));
        default: send_request(make_edge(e, $urandom_range(0, 63), -1));
      endcase
    end
    for (int e = EDGES_DEF - HIGH_EDGES; e < EDGES_DEF; e++) begin
      send_request(make_edge(e, $urandom_range(0, 63), $urandom_range(0, 255)));
    end
    for (int n = 0; n < NODES_DEF; n++) send_request(random_range(n));
  endtask

  // Directed corners: full and empty state, zero, single, maximum and
  // saturated step counts, and ranges that run past the end of the table.
  task automatic test_directed_runs();
    send_request(make_range(0, EDGES_DEF - HIGH_EDGES, 1023));
    send_request(make_range(1, 1023, 1023));
    send_request(make_range(2, 600, 100));
    send_request(make_range(3, 511, 512));
    send_request(make_state('1));
    send_request(make_run(1));
    send_request(make_state('0));
    send_request(make_run(0));
    send_request(make_run(2));
    send_request(make_state(64'hA5A5_5A5A_F0F0_0F0F));
    send_request(make_run(64));
    send_request(make_run(127));
    send_request(make_edge(511, 63, -128));
    send_request(make_edge(0, 0, 127));
    send_request(make_run(3));
  endtask

  // Node count corners: one node, zero acting as one, above the maximum
  // acting as the maximum, and an odd middle value.
  task automatic test_node_count();
    int values[5] = '{1, 0, 127, 33, 64};
    foreach (values[i]) begin
      write_node_count(values[i]);
      send_request(make_state({$urandom, $urandom}));
      send_request(make_run($urandom_range(1, 5)));
    end
  endtask

  // Random part: fifteen requests drawn at random from table edits, fresh states
  // and runs, with occasional node count changes.
  task automatic test_random_traffic();
    int sent;
    int pick;
    sent = 0;
    while (sent < 15) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        write_node_count($urandom_range(0, 127));
      end else if (pick < 5) begin
        send_request(make_edge(($urandom_range(0, 3) == 0) ?
                               $urandom_range(0, EDGES_DEF - 1) :
                               $urandom_range(0, LOW_EDGES - 1),
                               $urandom_range(0, 63), $urandom_range(0, 255)));
        sent++;
      end else if (pick < 8) begin
        send_request(random_range($urandom_range(0, NODES_DEF - 1)));
        sent++;
      end else if (pick < 12) begin
        send_request(make_state({$urandom, $urandom}));
        sent++;
      end else begin
        // Long runs are rare; most ask for only a handful of steps.
        send_request(make_run(($urandom_range(0, 9) == 0) ?
                              $urandom_range(0, 127) : $urandom_range(1, 8)));
        sent++;
      end
    end
  endtask

  // Result side: pop is driven on the falling edge with random stalls, and a
  // result is taken at a rising edge where pop is high and empty is low.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
        case ($urandom_range(0, 19))
          0: stall = $urandom_range(20, 80);
          1, 2, 3, 4: stall = $urandom_range(1, 3);
          default: stall = 0;
        endcase
      end
    end
  end

  // Checks each popped state vector against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected result state=%h step=%0d last=%0b", $time,
                 out_item.state_vector, out_item.step_index, out_item.last);
        mismatches++;
      end else begin
        want = expected_states.pop_front();
        if (out_item.state_vector !== want.state_vector) begin
          $display("%0t: state_vector expected %h actual %h", $time,
                   want.state_vector, out_item.state_vector);
          mismatches++;
        end
        if (out_item.step_index !== want.step_index) begin
          $display("%0t: step_index expected %0d actual %0d", $time,
                   want.step_index, out_item.step_index);
          mismatches++;
        end
        if (out_item.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_item.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side accepts anything.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    load_network();
    test_directed_runs();
    test_node_count();
    test_random_traffic();
    wait_idle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
